>>> sv/thpd_pkg.sv
// Shared constants and types for the two-header packet deframer.
package thpd_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int STATE_LEN_DEF    = 16;
  localparam int EVENT_LEN_DEF    = 8;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 6;

  localparam logic [BYTE_W-1:0] HDR_STATE_0 = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_STATE_1 = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_EVENT_0 = 8'hBB;
  localparam logic [BYTE_W-1:0] HDR_EVENT_1 = 8'h66;

  typedef enum logic {
    KIND_STATE = 1'b0,
    KIND_EVENT = 1'b1
  } pkt_kind_t;

endpackage

>>> sv/thpd_window_ram.sv
// Byte window storage: one write port, one read port with registered read data.
module thpd_window_ram #(
  parameter int DEPTH = thpd_pkg::WINDOW_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [thpd_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [thpd_pkg::BYTE_W-1:0] rd_data
);
  import thpd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/two_header_packet_deframer_top.sv
// Two-header packet deframer: circular byte window in RAM plus scan/emit sequencer.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per request.
// The byte is written into a circular window of WINDOW_DEPTH bytes; when the
// window is full the oldest byte is overwritten. Only a packet that ends at the
// newest byte can become complete, so after each byte the sequencer reads the two
// header bytes at STATE_LEN and at EVENT_LEN back from the newest byte (AA 55 or
// BB 66), one RAM read per cycle, and picks the one that starts earlier.
// A hit streams the packet out of the RAM, oldest byte first, and empties the window.
// Output channel (out_valid/out_ready) carries kind, byte, offset and last flag
// from an output register, so the receiver may stall at any time.
// Sequencing: after each accepted byte the sequencer runs the header reads and the
// decide step before in_ready returns; after a hit it also reads and loads each packet
// byte in turn, waiting while the receiver stalls, and in_ready stays low until the last
// byte is loaded. The single RAM read port serialises these reads.
// Reset empties the window (fill count to zero) and drops any pending result;
// RAM contents are not cleared.
module two_header_packet_deframer_top #(
  parameter int WINDOW_DEPTH = thpd_pkg::WINDOW_DEPTH_DEF,
  parameter int STATE_LEN    = thpd_pkg::STATE_LEN_DEF,
  parameter int EVENT_LEN    = thpd_pkg::EVENT_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [thpd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_packet_kind,
  output logic [thpd_pkg::BYTE_W-1:0] out_packet_byte,
  output logic [thpd_pkg::OFF_W-1:0]  out_byte_offset,
  output logic                       out_last_byte
);
  import thpd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(WINDOW_DEPTH);
  localparam logic [FW-1:0] DEPTH_F  = FW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW-1:0] S_BACK   =
    AW'((WINDOW_DEPTH - (STATE_LEN % WINDOW_DEPTH)) % WINDOW_DEPTH);
  localparam logic [AW-1:0] E_BACK   =
    AW'((WINDOW_DEPTH - (EVENT_LEN % WINDOW_DEPTH)) % WINDOW_DEPTH);
  localparam logic [OFF_W-1:0] S_LAST = OFF_W'(STATE_LEN - 1);
  localparam logic [OFF_W-1:0] E_LAST = OFF_W'(EVENT_LEN - 1);
  localparam bit STATE_FIRST = (STATE_LEN >= EVENT_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_S0,
    ST_RD_S1,
    ST_RD_E0,
    ST_RD_E1,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     emit_ptr_r, emit_ptr_nxt;
  logic [OFF_W-1:0]  cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  last_off_r, last_off_nxt;
  pkt_kind_t         kind_r, kind_nxt;
  logic [BYTE_W-1:0] s0_r, s0_nxt, s1_r, s1_nxt, e0_r, e0_nxt;
  logic              out_valid_r, out_valid_nxt;
  pkt_kind_t         out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic              out_last_r, out_last_nxt;

  logic [AW-1:0]     s_base, e_base, rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              in_acc, s_hit, e_hit, pick_state, out_free;

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign s_base   = ptr_add(wr_ptr_r, S_BACK);
  assign e_base   = ptr_add(wr_ptr_r, E_BACK);
  assign out_free = !out_valid_r || out_ready;

  assign s_hit = (int'(fill_r) >= STATE_LEN) && (s0_r == HDR_STATE_0) &&
                 (s1_r == HDR_STATE_1);
  assign e_hit = (int'(fill_r) >= EVENT_LEN) && (e0_r == HDR_EVENT_0) &&
                 (rd_data == HDR_EVENT_1);
  assign pick_state = s_hit && (STATE_FIRST || !e_hit);

  always_comb begin
    unique case (state_r)
      ST_RD_S0: rd_addr = s_base;
      ST_RD_S1: rd_addr = ptr_inc(s_base);
      ST_RD_E0: rd_addr = e_base;
      ST_RD_E1: rd_addr = ptr_inc(e_base);
      default:  rd_addr = emit_ptr_r;
    endcase
  end

  thpd_window_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_ptr_r),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    emit_ptr_nxt  = emit_ptr_r;
    cnt_nxt       = cnt_r;
    last_off_nxt  = last_off_r;
    kind_nxt      = kind_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    e0_nxt        = e0_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          fill_nxt   = (fill_r == DEPTH_F) ? fill_r : fill_r + 1'b1;
          state_nxt  = ST_RD_S0;
        end
      end
      ST_RD_S0: state_nxt = ST_RD_S1;
      ST_RD_S1: begin
        s0_nxt    = rd_data;
        state_nxt = ST_RD_E0;
      end
      ST_RD_E0: begin
        s1_nxt    = rd_data;
        state_nxt = ST_RD_E1;
      end
      ST_RD_E1: begin
        e0_nxt    = rd_data;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (s_hit || e_hit) begin
          // packet ends at the newest byte, so the whole window is consumed
          fill_nxt     = '0;
          cnt_nxt      = '0;
          kind_nxt     = pick_state ? KIND_STATE : KIND_EVENT;
          last_off_nxt = pick_state ? S_LAST : E_LAST;
          emit_ptr_nxt = pick_state ? s_base : e_base;
          state_nxt    = ST_EMIT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_byte_nxt  = rd_data;
          out_off_nxt   = cnt_r;
          out_last_nxt  = (cnt_r == last_off_r);
          if (cnt_r == last_off_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt      = cnt_r + 1'b1;
            emit_ptr_nxt = ptr_inc(emit_ptr_r);
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    emit_ptr_r <= emit_ptr_nxt;
    cnt_r      <= cnt_nxt;
    last_off_r <= last_off_nxt;
    kind_r     <= kind_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    e0_r       <= e0_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_off_r  <= out_off_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packet_kind = out_kind_r;
  assign out_packet_byte = out_byte_r;
  assign out_byte_offset = out_off_r;
  assign out_last_byte   = out_last_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("window fill count beyond depth");

  a_emit_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && (s_hit || e_hit)) |=> (fill_r == '0))
    else $error("window not emptied after packet found");

  a_emit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) |-> (fill_r == '0))
    else $error("window refilled during packet emission");

  a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |->
      (out_byte_offset == ((out_packet_kind == KIND_EVENT) ? E_LAST : S_LAST)))
    else $error("last byte flagged at wrong offset");
`endif

endmodule

>>> test/tb_two_header_packet_deframer_top.sv
// Self-checking testbench for the two-header packet deframer: byte driver, beat monitor, scoreboard.
`timescale 1ns / 100ps

module tb_two_header_packet_deframer_top;
  import thpd_pkg::*;

  localparam int WIN_DEPTH  = WINDOW_DEPTH_DEF;
  localparam int ST_LEN     = STATE_LEN_DEF;
  localparam int EV_LEN     = EVENT_LEN_DEF;
  localparam int RAND_BYTES = 95;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    pkt_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic [OFF_W-1:0]  offset;
    logic              last;
  } pkt_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_packet_kind;
  logic [BYTE_W-1:0]   out_packet_byte;
  logic [OFF_W-1:0]    out_byte_offset;
  logic                out_last_byte;

  logic [BYTE_W-1:0] rx_bytes_pending[$];
  logic [BYTE_W-1:0] rx_window[$];
  pkt_beat_t         beats_expected[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int bytes_accepted = 0;
  int window_overflows = 0;
  int beats_checked = 0;
  int state_pkts = 0;
  int event_pkts = 0;
  int bytes_queued = 0;

  two_header_packet_deframer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packet_kind (out_packet_kind),
    .out_packet_byte (out_packet_byte),
    .out_byte_offset (out_byte_offset),
    .out_last_byte   (out_last_byte)
  );

  always #4 clk = ~clk;

  // window model: append the byte, then pull out every complete packet, oldest header first
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    int        i;
    int        k;
    int        start;
    int        len;
    bit        found;
    pkt_kind_t kind;
    pkt_beat_t beat;
    if (rx_window.size() >= WIN_DEPTH) begin
      void'(rx_window.pop_front());
      window_overflows++;
    end
    rx_window.push_back(b);
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      start = 0;
      len = 0;
      kind = KIND_STATE;
      for (i = 0; i + 1 < rx_window.size(); i++) begin
        if (rx_window[i] == HDR_STATE_0 && rx_window[i+1] == HDR_STATE_1 &&
            rx_window.size() - i >= ST_LEN) begin
          start = i; len = ST_LEN; kind = KIND_STATE; found = 1'b1;
          break;
        end
        if (rx_window[i] == HDR_EVENT_0 && rx_window[i+1] == HDR_EVENT_1 &&
            rx_window.size() - i >= EV_LEN) begin
          start = i; len = EV_LEN; kind = KIND_EVENT; found = 1'b1;
          break;
        end
      end
      if (found) begin
        for (k = 0; k < len; k++) begin
          beat.kind   = kind;
          beat.data   = rx_window[start + k];
          beat.offset = k[OFF_W-1:0];
          beat.last   = (k + 1 == len);
          beats_expected.push_back(beat);
        end
        for (k = 0; k < start + len; k++) void'(rx_window.pop_front());
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        absorb_rx_byte(in_rx_byte);
        bytes_accepted++;
      end
      if (rx_bytes_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_bytes_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pkt_beat_t exp_beat;
    pkt_beat_t got_beat;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_beat = {pkt_kind_t'(out_packet_kind), out_packet_byte, out_byte_offset,
                    out_last_byte};
        if (beats_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: expected none, got kind=%0d byte=%02h off=%0d last=%0d",
                   $time, got_beat.kind, got_beat.data, got_beat.offset, got_beat.last);
        end else begin
          exp_beat = beats_expected.pop_front();
          beats_checked++;
          if (got_beat.kind !== exp_beat.kind || got_beat.data !== exp_beat.data ||
              got_beat.offset !== exp_beat.offset || got_beat.last !== exp_beat.last) begin
            errors++;
            $display("%0t: beat mismatch: expected kind=%0d byte=%02h off=%0d last=%0d,",
                     $time, exp_beat.kind, exp_beat.data, exp_beat.offset, exp_beat.last);
            $display("    got kind=%0d byte=%02h off=%0d last=%0d",
                     got_beat.kind, got_beat.data, got_beat.offset, got_beat.last);
          end
          if (exp_beat.last && exp_beat.kind == KIND_STATE) state_pkts++;
          if (exp_beat.last && exp_beat.kind == KIND_EVENT) event_pkts++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  // random byte, biased toward header values so headers show up in noise
  function automatic logic [BYTE_W-1:0] line_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 7))
      0: b = HDR_STATE_0;
      1: b = HDR_STATE_1;
      2: b = HDR_EVENT_0;
      3: b = HDR_EVENT_1;
      default: b = $urandom_range(0, 255);
    endcase
    return b;
  endfunction

  task automatic queue_noise(input int n);
    int i;
    for (i = 0; i < n; i++) queue_byte(line_byte());
  endtask

  task automatic queue_packet(input pkt_kind_t kind, input int body_len);
    int i;
    if (kind == KIND_STATE) begin
      queue_byte(HDR_STATE_0);
      queue_byte(HDR_STATE_1);
    end else begin
      queue_byte(HDR_EVENT_0);
      queue_byte(HDR_EVENT_1);
    end
    for (i = 0; i < body_len; i++) queue_byte($urandom_range(0, 255));
  endtask

  task automatic wait_drained();
    while (!(rx_bytes_pending.size() == 0 && !in_valid && beats_expected.size() == 0))
      @(posedge clk);
  endtask

  initial begin
    int        phase;
    int        phase_start;
    bit        long_noise_done;
    pkt_kind_t kind;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // event packet completes inside an unfinished state header
    queue_byte(HDR_STATE_0);
    queue_byte(HDR_STATE_1);
    queue_byte(HDR_EVENT_0);
    queue_byte(HDR_EVENT_1);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    queue_byte(8'hFE);
    // full state packet with extreme bytes
    queue_byte(HDR_STATE_0);
    queue_byte(HDR_STATE_1);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_noise(10);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      phase_start = bytes_queued;
      long_noise_done = (phase == 0 || phase == 2);
      while (bytes_queued - phase_start < RAND_BYTES) begin
        kind = pkt_kind_t'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            queue_noise($urandom_range(0, 3));
            queue_packet(kind, (kind == KIND_STATE ? ST_LEN : EV_LEN) - 2);
          end
          6, 7: begin
            // broken frame: header with a short body, then resync
            queue_packet(kind, $urandom_range(0, 5));
            queue_noise($urandom_range(0, 3));
          end
          8: queue_noise($urandom_range(2, 8));
          default: begin
            if (!long_noise_done) begin
              // overrun the window; a late header still has to be found
              queue_noise(WIN_DEPTH + $urandom_range(2, 8));
              queue_packet(KIND_EVENT, EV_LEN - 2);
              long_noise_done = 1'b1;
            end
          end
        endcase
      end
      wait_drained();
      repeat (12) @(posedge clk);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (beats_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, beats_expected.size());
    end
    $display("Sent %0d bytes (%0d window overruns) under four idle/stall mixes;",
             bytes_accepted, window_overflows);
    $display("checked %0d beats in %0d state and %0d event packets, %0d errors.",
             beats_checked, state_pkts, event_pkts, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
